[sv/spi_clock_divider_search_core_macros.svh]
// assertion helpers shared by the search core and its divider
`ifndef SPI_CLOCK_DIVIDER_SEARCH_CORE_MACROS_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SCSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SCSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/scsd_pkg.sv]
`timescale 1ns / 1ps
package scsd_pkg;

  // field and register widths
  localparam int PERIPH_W   = 29;
  localparam int PRESC_W    = 8;
  localparam int TARGET_W   = 27;
  localparam int ECON_Q_W   = 6;
  localparam int ECON_A_W   = 2;
  localparam int ECON_B_W   = 2;
  localparam int ECON_C_W   = 1;
  localparam int ACHIEVED_W = 28;

  // search limits
  localparam int Q_MAX_DEF   = 64;
  localparam int ABC_MAX_DEF = 8;
  localparam int B_LIMIT     = 3;
  localparam int MIN_PERIOD  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PERIPH_W;

  localparam logic [CFG_IDX_W-1:0] REG_PERIPH_CLOCK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_PRESC = CFG_IDX_W'(1);

  localparam logic [PERIPH_W-1:0] PERIPH_RST = PERIPH_W'(200000000);
  localparam logic [PRESC_W-1:0]  PRESC_RST  = PRESC_W'(0);

endpackage

[sv/scsd_div.sv]
`timescale 1ns / 1ps
`include "spi_clock_divider_search_core_macros.svh"
module scsd_div
  import scsd_pkg::*;
#(
  parameter int UW  = 48,
  parameter int QDW = 29,
  parameter int CW  = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [UW-1:0]  dividend_i,
  input  logic [UW-1:0]  divisor_i,
  input  logic [CW-1:0]  nbits_i,
  output logic           busy_o,
  output logic [QDW-1:0] quotient_o
);

  // restoring divider, one quotient bit per cycle; divisor_i is pre-aligned
  // to the weight of the top quotient bit
  logic           busy_q;
  logic [CW-1:0]  cnt_q;
  logic [UW-1:0]  rem_q;
  logic [UW-1:0]  dv_q;
  logic [QDW-1:0] quo_q;
  logic           ge;
  logic [UW-1:0]  diff;

  assign ge   = (rem_q >= dv_q);
  assign diff = rem_q - dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dv_q  <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff;
      end
      dv_q  <= dv_q >> 1;
      quo_q <= {quo_q[QDW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  `SCSD_ASSERT_IMP(a_div_no_restart, start_i, !busy_q, "divider started while busy")
  `SCSD_ASSERT_IMP(a_div_cnt_live, busy_q, cnt_q != '0, "divider busy with empty count")
  `SCSD_ASSERT_NXT(a_div_finish, busy_q && cnt_q == CW'(1), !busy_q,
                   "divider failed to finish")

endmodule

[sv/scsd_enc.sv]
`timescale 1ns / 1ps
module scsd_enc
  import scsd_pkg::*;
#(
  parameter int ABCW = 4
) (
  input  logic [ABCW-1:0]     abc_i,
  output logic [ECON_A_W-1:0] econ_a_o,
  output logic [ECON_B_W-1:0] econ_b_o,
  output logic [ECON_C_W-1:0] econ_c_o
);

  logic [ABCW-1:0] half;
  logic [ABCW-1:0] ea;
  logic            over;

  // split the bit period into phases a, b and c
  always_comb begin
    half = abc_i >> 1;
    over = (half > ABCW'(B_LIMIT));
    ea   = half + ABCW'(abc_i[0]) - ABCW'(1);
    econ_a_o = ea[ECON_A_W-1:0];
    econ_b_o = over ? ECON_B_W'(B_LIMIT) : ECON_B_W'(half);
    econ_c_o = over ? ECON_C_W'(half - ABCW'(B_LIMIT)) : '0;
  end

endmodule

[sv/spi_clock_divider_search_core.sv]
`timescale 1ns / 1ps
// spi clock divider search
// in channel: target_baud_hz_i with in_valid_i/in_ready_o; one transfer per search
// out channel: econ q/a/b/c fields and achieved_baud_hz_o with out_valid_o/out_ready_i
// cfg channel: cfg_index_i 0 writes periph_clock_hz, 1 writes quantum_prescaler;
//   other indexes are dropped; cfg_ready_o is always high
// in_ready_o is high only while the search engine is idle
// search: 1 to 7 splits tried between input transfer and out_valid_o, stopping early
//   on an exact even split
// per split: one multiply for the divisor, a pass through the shared restoring
//   divider for the rounded q, one multiply and one compare for the error
// the achieved rate takes a further pass through the same divider
// one item at a time; a new search starts the cycle after the result is loaded
// the result sits in the output register; if the receiver stalls with an older
//   result still pending, the engine holds its finished result until that clears
// reset: config back to 200 MHz and prescaler 0, engine idle, no result pending
`include "spi_clock_divider_search_core_macros.svh"
module spi_clock_divider_search_core
  import scsd_pkg::*;
#(
  parameter int Q_MAX   = Q_MAX_DEF,
  parameter int ABC_MAX = ABC_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // target rate
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TARGET_W-1:0]   target_baud_hz_i,
  // encoded divider
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ECON_Q_W-1:0]   econ_q_o,
  output logic [ECON_A_W-1:0]   econ_a_o,
  output logic [ECON_B_W-1:0]   econ_b_o,
  output logic [ECON_C_W-1:0]   econ_c_o,
  output logic [ACHIEVED_W-1:0] achieved_baud_hz_o
);

  // widths derived from the search limits
  localparam int PW   = PRESC_W + 1;                       // prescaler plus one
  localparam int ABCW = $clog2(ABC_MAX + 1);
  localparam int QW   = $clog2(Q_MAX + 1);
  localparam int QSW  = (QW > ABCW) ? QW : ABCW;           // q after swap
  localparam int DDW  = PW + ABCW + TARGET_W;              // d = p * abc * t
  localparam int MAW  = DDW;
  localparam int MBW  = (PW > QSW) ? PW : QSW;
  localparam int PRW  = MAW + MBW;
  localparam int DENW = PW + ABCW + QSW;                   // p * q * abc
  localparam int QDW  = (QW > PERIPH_W) ? QW : PERIPH_W;
  localparam int CW   = $clog2(QDW + 1);
  localparam int UWA  = DDW + QW;
  localparam int UWB  = DENW + PERIPH_W - 1;
  localparam int UW   = (UWA > UWB) ? UWA : UWB;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PT,
    S_PTCAP,
    S_D,
    S_DIV,
    S_DWAIT,
    S_E,
    S_ERR,
    S_SEL,
    S_SWAP,
    S_DEN1,
    S_DEN2,
    S_FDIV,
    S_FWAIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [PERIPH_W-1:0] periph_q;
  logic [PRESC_W-1:0]  presc_q;

  // search datapath
  logic [TARGET_W-1:0]    t_q;
  logic [PW+TARGET_W-1:0] pt_q;
  logic [ABCW-1:0]        abc_q;
  logic [DDW-1:0]         d_q;
  logic [QW-1:0]          q_q;
  logic [PRW-1:0]         err_q;
  logic [PRW-1:0]         best_err_q;
  logic [QSW-1:0]         best_q_q;
  logic [ABCW-1:0]        best_abc_q;
  logic                   first_q;
  logic [PRW-1:0]         mul_p_q;

  // output register
  logic                  out_valid_q;
  logic [ECON_Q_W-1:0]   econ_q_q;
  logic [ECON_A_W-1:0]   econ_a_q;
  logic [ECON_B_W-1:0]   econ_b_q;
  logic [ECON_C_W-1:0]   econ_c_q;
  logic [ACHIEVED_W-1:0] achieved_q;

  logic [PW-1:0]  p_val;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;

  logic           div_start;
  logic [UW-1:0]  div_dividend;
  logic [UW-1:0]  div_divisor;
  logic [CW-1:0]  div_nbits;
  logic           div_busy;
  logic [QDW-1:0] div_quo;

  logic [QW-1:0]  q_raw;
  logic [QW-1:0]  q_clamp;
  logic           sel_take;
  logic [ABCW-1:0] sel_abc;
  logic           sel_stop;
  logic           do_swap;
  logic           in_fire;
  logic           out_free;
  logic           out_load;

  logic [ECON_A_W-1:0] enc_a;
  logic [ECON_B_W-1:0] enc_b;
  logic [ECON_C_W-1:0] enc_c;

  assign p_val    = PW'(presc_q) + PW'(1);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_FWAIT) && !div_busy && out_free;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PT: begin
        mul_a = MAW'(t_q);
        mul_b = MBW'(p_val);
      end
      S_D: begin
        mul_a = MAW'(pt_q);
        mul_b = MBW'(abc_q);
      end
      S_E: begin
        mul_a = d_q;
        mul_b = MBW'(q_q);
      end
      S_DEN1: begin
        mul_a = MAW'(p_val);
        mul_b = MBW'(best_abc_q);
      end
      S_DEN2: begin
        mul_a = MAW'(mul_p_q[PW+ABCW-1:0]);
        mul_b = MBW'(best_q_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests: rounded q = (2f + d) / 2d, then f / (p * q * abc)
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_nbits    = '0;
    case (state_q)
      S_DIV: begin
        div_start    = 1'b1;
        div_dividend = UW'({periph_q, 1'b0}) + UW'(mul_p_q[DDW-1:0]);
        div_divisor  = UW'({mul_p_q[DDW-1:0], 1'b0}) << (QW - 1);
        div_nbits    = CW'(QW);
      end
      S_FDIV: begin
        div_start    = 1'b1;
        div_dividend = UW'(periph_q);
        div_divisor  = UW'(mul_p_q[DENW-1:0]) << (PERIPH_W - 1);
        div_nbits    = CW'(PERIPH_W);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // q saturates to all ones when the true quotient overflows, so the clamp holds
  assign q_raw = div_quo[QW-1:0];

  always_comb begin
    if (q_raw > QW'(Q_MAX)) begin
      q_clamp = QW'(Q_MAX);
    end else if (q_raw == '0 ||
                 (q_raw == QW'(1) && (ABCW+1)'(abc_q) < (ABCW+1)'(MIN_PERIOD))) begin
      q_clamp = QW'(2);
    end else begin
      q_clamp = q_raw;
    end
  end

  // keep the smaller error; on a tie prefer the newer split unless best is odd
  assign sel_take = first_q || (err_q < best_err_q) ||
                    ((err_q == best_err_q) && !best_abc_q[0]);
  assign sel_abc  = sel_take ? abc_q : best_abc_q;
  assign sel_stop = (err_q == '0) && !sel_abc[0];

  // exchange an even small q with an odd split
  assign do_swap = (best_q_q <= QSW'(ABC_MAX)) && best_abc_q[0] && !best_q_q[0];

  scsd_div #(
    .UW  (UW),
    .QDW (QDW),
    .CW  (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .nbits_i    (div_nbits),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  scsd_enc #(
    .ABCW (ABCW)
  ) u_enc (
    .abc_i    (best_abc_q),
    .econ_a_o (enc_a),
    .econ_b_o (enc_b),
    .econ_c_o (enc_c)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periph_q <= PERIPH_RST;
      presc_q  <= PRESC_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PERIPH_CLOCK: periph_q <= cfg_data_i[PERIPH_W-1:0];
        REG_QUANTUM_PRESC: presc_q <= cfg_data_i[PRESC_W-1:0];
        default: begin
          periph_q <= periph_q;
        end
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      econ_q_q    <= '0;
      econ_a_q    <= '0;
      econ_b_q    <= '0;
      econ_c_q    <= '0;
      achieved_q  <= '0;
    end else begin
      // a drained result is replaced in the same cycle when a new one loads
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_PT;
          end
        end
        S_PT:    state_q <= S_PTCAP;
        S_PTCAP: state_q <= S_D;
        S_D:     state_q <= S_DIV;
        S_DIV:   state_q <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            state_q <= S_E;
          end
        end
        S_E:   state_q <= S_ERR;
        S_ERR: state_q <= S_SEL;
        S_SEL: begin
          if (sel_stop || abc_q == ABCW'(2)) begin
            state_q <= S_SWAP;
          end else begin
            state_q <= S_D;
          end
        end
        S_SWAP: state_q <= S_DEN1;
        S_DEN1: state_q <= S_DEN2;
        S_DEN2: state_q <= S_FDIV;
        S_FDIV: state_q <= S_FWAIT;
        S_FWAIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            econ_q_q    <= ECON_Q_W'(best_q_q - QSW'(1));
            econ_a_q    <= enc_a;
            econ_b_q    <= enc_b;
            econ_c_q    <= enc_c;
            achieved_q  <= ACHIEVED_W'(div_quo);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // search datapath registers
  always_ff @(posedge clk_i) begin
    mul_p_q <= PRW'(mul_a) * PRW'(mul_b);
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // zero target counts as 1 Hz
          t_q     <= (target_baud_hz_i == '0) ? TARGET_W'(1) : target_baud_hz_i;
          abc_q   <= ABCW'(ABC_MAX);
          first_q <= 1'b1;
        end
      end
      S_PTCAP: pt_q <= mul_p_q[PW+TARGET_W-1:0];
      S_DIV:   d_q  <= mul_p_q[DDW-1:0];
      S_DWAIT: begin
        if (!div_busy) begin
          q_q <= q_clamp;
        end
      end
      S_ERR: begin
        // period error scaled by f * t
        err_q <= (mul_p_q >= PRW'(periph_q)) ? mul_p_q - PRW'(periph_q)
                                             : PRW'(periph_q) - mul_p_q;
      end
      S_SEL: begin
        first_q <= 1'b0;
        abc_q   <= abc_q - ABCW'(1);
        if (sel_take) begin
          best_err_q <= err_q;
          best_abc_q <= abc_q;
          best_q_q   <= QSW'(q_q);
        end
      end
      S_SWAP: begin
        if (do_swap) begin
          best_q_q   <= QSW'(best_abc_q);
          best_abc_q <= best_q_q[ABCW-1:0];
        end
      end
      default: begin
        first_q <= first_q;
      end
    endcase
  end

  assign cfg_ready_o        = 1'b1;
  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign econ_q_o           = econ_q_q;
  assign econ_a_o           = econ_a_q;
  assign econ_b_o           = econ_b_q;
  assign econ_c_o           = econ_c_q;
  assign achieved_baud_hz_o = achieved_q;

  `SCSD_ASSERT_IMP(a_abc_range, state_q == S_SEL,
                   abc_q >= ABCW'(2) && abc_q <= ABCW'(ABC_MAX), "split out of range")
  `SCSD_ASSERT_IMP(a_q_range, state_q == S_E,
                   q_q >= QW'(1) && q_q <= QW'(Q_MAX), "divider q out of range")
  `SCSD_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "input taken while search pending")
  `SCSD_ASSERT(a_no_div_mul_overlap, !(div_start && div_busy), "divider restarted while busy")

endmodule
